FILE: src/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the RLE byte decoder
// Phase encoding, status codes, register map and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int SIZE_W        = 25;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 4;
    localparam int STAT_W        = 3;
    localparam int OUT_DATA_W    = 64;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int OUT_LANES_DEF = 8;

    localparam logic [SIZE_W-1:0] MAX_ENTRY_BYTES = SIZE_W'(16777216);

    localparam int               RUN_FLAG_BIT = 7;
    localparam logic [BYTE_W-1:0] RUN_BIAS    = 8'd3;
    localparam logic [BYTE_W-1:0] LIT_BIAS    = 8'd1;

    localparam logic [APB_ADDR_W-3:0] REG_EXPECTED_SIZE = 1'd0;

    localparam logic [STAT_W-1:0] STAT_OK            = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RUN_NO_VALUE  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RUN_OVERSIZE  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_LIT_OVERFLOW  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SIZE_MISMATCH = 3'd4;

    typedef enum logic [2:0] {
        ST_CTRL,
        ST_RUNVAL,
        ST_LIT,
        ST_DISCARD,
        ST_RUN_EMIT
    } phase_t;

    typedef struct packed {
        logic                err_valid;
        logic [STAT_W-1:0]   err_code;
        logic                load_run;
        logic                load_lit;
        logic                take_runval;
        logic                emit_group;
        logic                emit_lit;
        logic                clear_entry;
    } dp_cmd_t;

    typedef struct packed {
        logic over_limit;
        logic is_run;
        logic run_too_big;
        logic lit_too_big;
        logic lit_ends;
        logic last_group;
        logic out_free;
    } dp_status_t;

endpackage

FILE: src/rle_byte_decoder.sv
// ----------------------------------------------------------------------------
// rle_byte_decoder: run-length decoder, one entry at a time
// Takes one stored byte per word and returns decoded bytes in groups of up
// to OUT_LANES lanes, with size checks and an error status per entry.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  in       | sink      | in_valid / in_stall  | in_byte, last_in
//  out      | source    | out_valid / out_stall| out_data, out_count, group_end,
//           |           |                      | entry_done, status
//  cfg      | APB slave | psel/penable/pready  | paddr, pwdata, prdata
//
//  Control and literal words are taken every cycle as long as the output
//  register drains. A run value word is latched first, then its groups
//  come from the run emitter, input held.
//  Reset (rst_n low, asynchronous) returns to the control-byte phase with
//  all counters cleared and the size register at 0.
//  Output stall holds the output register. The input stalls while the output
//  register is full and cannot drain, except while dropping the rest of a
//  failed entry, and stays stalled while a run's groups are emitted.
//
module rle_byte_decoder
    import rbd_pkg::*;
#(
    parameter int OUT_LANES = OUT_LANES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input words
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     in_byte,
    input  logic                  last_in,
    // result words
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [CNT_W-1:0]      out_count,
    output logic                  group_end,
    output logic                  entry_done,
    output logic [STAT_W-1:0]     status,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SIZE_W-1:0] expected_size;
    dp_cmd_t           dp_cmd;
    dp_status_t        dp_status;

    // declared entry size register
    rbd_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .expected_size (expected_size)
    );

    // phase sequencer: decides errors, loads and emits from datapath flags
    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_in   (last_in),
        .dp_status (dp_status),
        .in_stall  (in_stall),
        .dp_cmd    (dp_cmd)
    );

    // counters, checks, group builder and output register
    rbd_dp #(
        .OUT_LANES (OUT_LANES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .last_in       (last_in),
        .expected_size (expected_size),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_data      (out_data),
        .out_count     (out_count),
        .group_end     (group_end),
        .entry_done    (entry_done),
        .status        (status)
    );

endmodule

FILE: src/rbd_cfg.sv
// ----------------------------------------------------------------------------
// rbd_cfg: configuration register file
// APB-style slave holding the declared decoded size of the entry.
// ----------------------------------------------------------------------------
module rbd_cfg
    import rbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SIZE_W-1:0]     expected_size
);

    logic [SIZE_W-1:0]       size_reg;
    logic [SIZE_W-1:0]       size_next;
    logic [APB_ADDR_W-3:0]   reg_idx;
    logic                    wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        size_next = size_reg;
        if (wr_en && (reg_idx == REG_EXPECTED_SIZE))
        begin
            size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_EXPECTED_SIZE)
        begin
            prdata = APB_DATA_W'(size_reg);
        end
    end

    assign expected_size = size_reg;

endmodule

FILE: src/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl: decoder controller
// Phase state machine; issues datapath commands and drives input stall.
// ----------------------------------------------------------------------------
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       last_in,
    input  dp_status_t dp_status,
    output logic       in_stall,
    output dp_cmd_t    dp_cmd
);

    phase_t state_reg;
    phase_t state_next;
    logic   accept;

    always_comb
    begin
        unique case (state_reg)
            ST_CTRL, ST_RUNVAL, ST_LIT: in_stall = !dp_status.out_free;
            ST_DISCARD:                 in_stall = 1'b0;
            default:                    in_stall = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CTRL:
            begin
                if (accept)
                begin
                    if (dp_status.over_limit)
                    begin
                        state_next = last_in ? ST_CTRL : ST_DISCARD;
                    end
                    else if (dp_status.is_run)
                    begin
                        if (last_in)
                        begin
                            state_next = ST_CTRL;
                        end
                        else if (dp_status.run_too_big)
                        begin
                            state_next = ST_DISCARD;
                        end
                        else
                        begin
                            state_next = ST_RUNVAL;
                        end
                    end
                    else if (last_in || dp_status.lit_too_big)
                    begin
                        state_next = last_in ? ST_CTRL : ST_DISCARD;
                    end
                    else
                    begin
                        state_next = ST_LIT;
                    end
                end
            end
            ST_RUNVAL:
            begin
                if (accept)
                begin
                    state_next = ST_RUN_EMIT;
                end
            end
            ST_LIT:
            begin
                if (accept && (last_in || dp_status.lit_ends))
                begin
                    state_next = ST_CTRL;
                end
            end
            ST_DISCARD:
            begin
                if (accept && last_in)
                begin
                    state_next = ST_CTRL;
                end
            end
            ST_RUN_EMIT:
            begin
                if (dp_status.out_free && dp_status.last_group)
                begin
                    state_next = ST_CTRL;
                end
            end
            default:
            begin
                state_next = ST_CTRL;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        dp_cmd = '0;
        dp_cmd.err_code = STAT_OK;
        unique case (state_reg)
            ST_CTRL:
            begin
                if (accept)
                begin
                    if (dp_status.over_limit)
                    begin
                        dp_cmd.err_valid = 1'b1;
                        dp_cmd.err_code  = STAT_SIZE_MISMATCH;
                    end
                    else if (dp_status.is_run)
                    begin
                        if (last_in)
                        begin
                            dp_cmd.err_valid = 1'b1;
                            dp_cmd.err_code  = STAT_RUN_NO_VALUE;
                        end
                        else if (dp_status.run_too_big)
                        begin
                            dp_cmd.err_valid = 1'b1;
                            dp_cmd.err_code  = STAT_RUN_OVERSIZE;
                        end
                        else
                        begin
                            dp_cmd.load_run = 1'b1;
                        end
                    end
                    else if (last_in || dp_status.lit_too_big)
                    begin
                        dp_cmd.err_valid = 1'b1;
                        dp_cmd.err_code  = STAT_LIT_OVERFLOW;
                    end
                    else
                    begin
                        dp_cmd.load_lit = 1'b1;
                    end
                end
            end
            ST_RUNVAL:
            begin
                if (accept)
                begin
                    dp_cmd.take_runval = 1'b1;
                    dp_cmd.clear_entry = last_in;
                end
            end
            ST_LIT:
            begin
                if (accept)
                begin
                    dp_cmd.emit_lit    = 1'b1;
                    dp_cmd.clear_entry = last_in;
                end
            end
            ST_DISCARD:
            begin
                if (accept && last_in)
                begin
                    dp_cmd.clear_entry = 1'b1;
                end
            end
            ST_RUN_EMIT:
            begin
                dp_cmd.emit_group = dp_status.out_free;
            end
            default:
            begin
                dp_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CTRL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/rbd_dp.sv
// ----------------------------------------------------------------------------
// rbd_dp: decoder datapath
// Entry counters, size checks, run group builder and the output register.
// ----------------------------------------------------------------------------
module rbd_dp
    import rbd_pkg::*;
#(
    parameter int OUT_LANES = OUT_LANES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [BYTE_W-1:0]     in_byte,
    input  logic                  last_in,
    input  logic [SIZE_W-1:0]     expected_size,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            dp_status,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [CNT_W-1:0]      out_count,
    output logic                  group_end,
    output logic                  entry_done,
    output logic [STAT_W-1:0]     status
);

    localparam int LANE_DATA_W = OUT_LANES * BYTE_W;
    localparam logic [BYTE_W-1:0] LANES_B = BYTE_W'(OUT_LANES);

    logic [SIZE_W-1:0]      produced_reg,    produced_next;
    logic [BYTE_W-1:0]      literal_left_reg, literal_left_next;
    logic [BYTE_W-1:0]      run_length_reg,  run_length_next;
    logic [BYTE_W-1:0]      run_left_reg,    run_left_next;
    logic [BYTE_W-1:0]      run_byte_reg,    run_byte_next;
    logic                   run_last_reg,    run_last_next;
    logic [STAT_W-1:0]      run_stat_reg,    run_stat_next;

    logic                   out_valid_reg,   out_valid_next;
    logic [LANE_DATA_W-1:0] data_reg,        data_next;
    logic [CNT_W-1:0]       count_reg,       count_next;
    logic                   gend_reg,        gend_next;
    logic                   done_reg,        done_next;
    logic [STAT_W-1:0]      stat_reg,        stat_next;

    logic [BYTE_W-1:0]      run_len;
    logic [BYTE_W-1:0]      lit_len;
    logic [SIZE_W-1:0]      remaining;
    logic                   over_produced;
    logic [SIZE_W-1:0]      lit_prod;
    logic [BYTE_W-1:0]      lit_left_dec;
    logic [STAT_W-1:0]      lit_stat;
    logic [SIZE_W-1:0]      run_prod;
    logic [BYTE_W-1:0]      grp_n;
    logic                   grp_end;
    logic [LANE_DATA_W-1:0] grp_data;
    logic                   out_free;

    // control byte decode and size checks
    assign run_len       = {1'b0, in_byte[RUN_FLAG_BIT-1:0]} + RUN_BIAS;
    assign lit_len       = {1'b0, in_byte[RUN_FLAG_BIT-1:0]} + LIT_BIAS;
    assign remaining     = expected_size - produced_reg;
    assign over_produced = produced_reg > expected_size;

    assign lit_prod     = produced_reg + SIZE_W'(1);
    assign lit_left_dec = (literal_left_reg != '0) ? literal_left_reg - 8'd1 : '0;
    always_comb
    begin
        if (lit_left_dec != '0)
        begin
            lit_stat = STAT_LIT_OVERFLOW;
        end
        else
        begin
            lit_stat = (lit_prod == expected_size) ? STAT_OK : STAT_SIZE_MISMATCH;
        end
    end

    assign run_prod = produced_reg + SIZE_W'(run_length_reg);

    // one output group of the pending run
    assign grp_end = run_left_reg <= LANES_B;
    assign grp_n   = grp_end ? run_left_reg : LANES_B;
    always_comb
    begin
        for (int i = 0; i < OUT_LANES; i++)
        begin
            grp_data[i*BYTE_W +: BYTE_W] = (BYTE_W'(i) < grp_n) ? run_byte_reg : '0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign dp_status.over_limit  = (produced_reg == '0) && (expected_size > MAX_ENTRY_BYTES);
    assign dp_status.is_run      = in_byte[RUN_FLAG_BIT];
    assign dp_status.run_too_big = over_produced || (SIZE_W'(run_len) > remaining);
    assign dp_status.lit_too_big = over_produced || (SIZE_W'(lit_len) > remaining);
    assign dp_status.lit_ends    = lit_left_dec == '0;
    assign dp_status.last_group  = grp_end;
    assign dp_status.out_free    = out_free;

    // entry state
    always_comb
    begin
        produced_next     = produced_reg;
        literal_left_next = literal_left_reg;
        run_length_next   = run_length_reg;
        run_left_next     = run_left_reg;
        run_byte_next     = run_byte_reg;
        run_last_next     = run_last_reg;
        run_stat_next     = run_stat_reg;
        if (dp_cmd.load_run)
        begin
            run_length_next = run_len;
        end
        if (dp_cmd.load_lit)
        begin
            literal_left_next = lit_len;
        end
        if (dp_cmd.emit_lit)
        begin
            produced_next     = lit_prod;
            literal_left_next = lit_left_dec;
        end
        if (dp_cmd.take_runval)
        begin
            produced_next   = run_prod;
            run_left_next   = run_length_reg;
            run_byte_next   = in_byte;
            run_last_next   = last_in;
            run_stat_next   = (run_prod == expected_size) ? STAT_OK : STAT_SIZE_MISMATCH;
            run_length_next = '0;
        end
        if (dp_cmd.emit_group)
        begin
            run_left_next = run_left_reg - grp_n;
        end
        if (dp_cmd.err_valid || dp_cmd.clear_entry)
        begin
            produced_next     = '0;
            literal_left_next = '0;
            run_length_next   = '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        data_next      = data_reg;
        count_next     = count_reg;
        gend_next      = gend_reg;
        done_next      = done_reg;
        stat_next      = stat_reg;
        if (dp_cmd.err_valid)
        begin
            out_valid_next = 1'b1;
            data_next      = '0;
            count_next     = '0;
            gend_next      = 1'b1;
            done_next      = 1'b1;
            stat_next      = dp_cmd.err_code;
        end
        else if (dp_cmd.emit_lit)
        begin
            out_valid_next = 1'b1;
            data_next      = LANE_DATA_W'(in_byte);
            count_next     = CNT_W'(1);
            gend_next      = 1'b1;
            done_next      = last_in;
            stat_next      = last_in ? lit_stat : STAT_OK;
        end
        else if (dp_cmd.emit_group)
        begin
            out_valid_next = 1'b1;
            data_next      = grp_data;
            count_next     = grp_n[CNT_W-1:0];
            gend_next      = grp_end;
            done_next      = grp_end && run_last_reg;
            stat_next      = (grp_end && run_last_reg) ? run_stat_reg : STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            produced_reg     <= '0;
            literal_left_reg <= '0;
            run_length_reg   <= '0;
            run_left_reg     <= '0;
            run_last_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            produced_reg     <= produced_next;
            literal_left_reg <= literal_left_next;
            run_length_reg   <= run_length_next;
            run_left_reg     <= run_left_next;
            run_last_reg     <= run_last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_byte_reg <= run_byte_next;
        run_stat_reg <= run_stat_next;
        data_reg     <= data_next;
        count_reg    <= count_next;
        gend_reg     <= gend_next;
        done_reg     <= done_next;
        stat_reg     <= stat_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = OUT_DATA_W'(data_reg);
    assign out_count  = count_reg;
    assign group_end  = gend_reg;
    assign entry_done = done_reg;
    assign status     = stat_reg;

endmodule
